[sv/sbc_pkg.sv]
package sbc_pkg;

   localparam int ACTION_W = 2;
   localparam int SECTOR_W = 24;
   localparam int SLOT_W   = 4;
   localparam int BLOCK_W  = 21;
   localparam int COUNT_W  = 8;
   localparam int BF_W     = 2;
   localparam int STAMP_W  = 32;
   localparam int LEN_MAX  = 255;

   localparam logic [ACTION_W-1:0] ACT_SINGLE = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_CONTIG = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_INVAL  = 2'd2;

   typedef struct packed {
      logic                hit;
      logic [SLOT_W-1:0]   slot;
      logic                read_issued;
      logic [BLOCK_W-1:0]  drive_block;
      logic [COUNT_W-1:0]  drive_count;
      logic                ok;
   } result_type;

   typedef struct packed {
      logic capture;
      logic decide;
      logic fill;
      logic load_out;
   } ctrl_cmd_type;

   typedef struct packed {
      logic req_lookup;
      logic scan_done;
      logic need_fill;
      logic fill_last;
      logic out_free;
   } ctrl_sts_type;

endpackage

[sv/sbc_ifs.sv]
interface sbc_req_if import sbc_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [SECTOR_W-1:0] sector;
   logic [SECTOR_W-1:0] last_sector;
   logic                read_ok;

   modport source (output valid, action, sector, last_sector, read_ok, input ready);
   modport sink   (input valid, action, sector, last_sector, read_ok, output ready);
endinterface

interface sbc_rsp_if import sbc_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               hit;
   logic [SLOT_W-1:0]  slot;
   logic               read_issued;
   logic [BLOCK_W-1:0] drive_block;
   logic [COUNT_W-1:0] drive_count;
   logic               ok;

   modport source (output valid, hit, slot, read_issued, drive_block, drive_count, ok,
                   input ready);
   modport sink   (input valid, hit, slot, read_issued, drive_block, drive_count, ok,
                   output ready);
endinterface

[sv/sector_buffer_cache_lru.sv]
// Tag store of a sector buffer cache with LRU replacement.
// req_ch carries one beat per request: action (single read, contiguous read,
// invalidate), sector, last_sector and read_ok, the outcome of the drive read
// that a miss causes. rsp_ch returns exactly one beat per request with hit,
// slot, read_issued, drive_block, drive_count and ok. csr_wr_en/csr_wr_data
// write the blocking factor; write it only while no request is in flight.
// A single read scans the standard slots; a contiguous read scans the file
// slots and, on a successful miss, then fills the file slots of its span;
// invalidate and unused codes skip the scan. One request is in work at a
// time; a new one is taken once the previous result has been loaded into
// the output register. Tags and use stamps sit in single-read RAMs that
// are walked one slot per cycle.
// Reset clears all valid bits, the use counter, the blocking factor and the
// output valid bit; there is no clearing pass. While the receiver stalls the
// result beat holds, and the next request finishes up to its result and then
// waits until the output register is free.
module sector_buffer_cache_lru import sbc_pkg::*; #(
   parameter int STD_SLOTS  = 8,
   parameter int FILE_SLOTS = 8
) (
   input logic            clock,
   input logic            reset,
   sbc_req_if.sink        req_ch,
   sbc_rsp_if.source      rsp_ch,
   input logic            csr_wr_en,
   input logic [BF_W-1:0] csr_wr_data
);

   ctrl_cmd_type cmd;
   ctrl_sts_type sts;
   result_type   rsp_data;

   sbc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   sbc_datapath #(.STD_SLOTS(STD_SLOTS), .FILE_SLOTS(FILE_SLOTS)) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_action      (req_ch.action),
      .req_sector      (req_ch.sector),
      .req_last_sector (req_ch.last_sector),
      .req_read_ok     (req_ch.read_ok),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .rsp_valid       (rsp_ch.valid),
      .rsp_ready       (rsp_ch.ready),
      .rsp_data        (rsp_data)
   );

   assign rsp_ch.hit         = rsp_data.hit;
   assign rsp_ch.slot        = rsp_data.slot;
   assign rsp_ch.read_issued = rsp_data.read_issued;
   assign rsp_ch.drive_block = rsp_data.drive_block;
   assign rsp_ch.drive_count = rsp_data.drive_count;
   assign rsp_ch.ok          = rsp_data.ok;

endmodule

[sv/sbc_ram.sv]
module sbc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/sbc_ctrl.sv]
module sbc_ctrl import sbc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  ctrl_sts_type sts,
   output ctrl_cmd_type cmd
);

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_SCAN   = 5'b00010,
      S_DECIDE = 5'b00100,
      S_FILL   = 5'b01000,
      S_DONE   = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = sts.req_lookup ? S_SCAN : S_DONE;
            end
         end
         S_SCAN: begin
            if (sts.scan_done) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            cmd.decide = 1'b1;
            state_in   = sts.need_fill ? S_FILL : S_DONE;
         end
         S_FILL: begin
            cmd.fill = 1'b1;
            if (sts.fill_last) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (sts.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[sv/sbc_datapath.sv]
module sbc_datapath import sbc_pkg::*; #(
   parameter int STD_SLOTS  = 8,
   parameter int FILE_SLOTS = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  ctrl_cmd_type        cmd,
   output ctrl_sts_type        sts,
   input  logic [ACTION_W-1:0] req_action,
   input  logic [SECTOR_W-1:0] req_sector,
   input  logic [SECTOR_W-1:0] req_last_sector,
   input  logic                req_read_ok,
   input  logic                csr_wr_en,
   input  logic [BF_W-1:0]     csr_wr_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output result_type          rsp_data
);

   localparam int TOTAL   = STD_SLOTS + FILE_SLOTS;
   localparam int IDX_W   = $clog2(TOTAL);
   localparam int LRU_AW  = (STD_SLOTS > 1) ? $clog2(STD_SLOTS) : 1;
   localparam int LEN_CAP = (FILE_SLOTS < LEN_MAX) ? FILE_SLOTS : LEN_MAX;

   logic [BF_W-1:0]     bf_ff, bf_in;
   logic [ACTION_W-1:0] act_ff, act_in;
   logic [SECTOR_W-1:0] sec_ff, sec_in;
   logic                rd_ok_ff, rd_ok_in;
   logic [COUNT_W-1:0]  len_ff, len_in;
   logic [STAMP_W-1:0]  use_ctr_ff, use_ctr_in;
   logic [TOTAL-1:0]    valid_ff, valid_in;
   logic                scan_on_ff, scan_on_in;
   logic [IDX_W-1:0]    scan_ptr_ff, scan_ptr_in;
   logic [IDX_W-1:0]    scan_last_ff, scan_last_in;
   logic                cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0]    cmp_idx_ff, cmp_idx_in;
   logic                found_ff, found_in;
   logic [IDX_W-1:0]    hit_idx_ff, hit_idx_in;
   logic                inval_found_ff, inval_found_in;
   logic [IDX_W-1:0]    inval_idx_ff, inval_idx_in;
   logic                min_have_ff, min_have_in;
   logic [IDX_W-1:0]    min_idx_ff, min_idx_in;
   logic [STAMP_W-1:0]  min_val_ff, min_val_in;
   logic [IDX_W-1:0]    fill_ptr_ff, fill_ptr_in;
   logic [SECTOR_W-1:0] fill_sec_ff, fill_sec_in;
   logic [COUNT_W-1:0]  fill_rem_ff, fill_rem_in;
   result_type          res_ff, res_in;
   logic                out_vld_ff, out_vld_in;
   result_type          out_ff, out_in;

   logic                tag_we;
   logic [IDX_W-1:0]    tag_waddr;
   logic [SECTOR_W-1:0] tag_wdata;
   logic [SECTOR_W-1:0] tag_rdata;
   logic                lru_we;
   logic [LRU_AW-1:0]   lru_waddr;
   logic [STAMP_W-1:0]  lru_rdata;

   logic [SECTOR_W-1:0] span_diff;
   logic [COUNT_W-1:0]  span_len;
   logic [SECTOR_W+2:0] block_wide;
   logic [BLOCK_W-1:0]  drive_block;
   logic [COUNT_W-1:0]  count_single;
   logic [COUNT_W-1:0]  count_contig;
   logic                cur_valid;
   logic                tag_match;
   logic [IDX_W-1:0]    victim_idx;

   sbc_ram #(.WIDTH(SECTOR_W), .DEPTH(TOTAL)) u_tag_ram (
      .clock   (clock),
      .wr_en   (tag_we),
      .wr_addr (tag_waddr),
      .wr_data (tag_wdata),
      .rd_addr (scan_ptr_ff),
      .rd_data (tag_rdata)
   );

   sbc_ram #(.WIDTH(STAMP_W), .DEPTH(STD_SLOTS)) u_lru_ram (
      .clock   (clock),
      .wr_en   (lru_we),
      .wr_addr (lru_waddr),
      .wr_data (use_ctr_ff),
      .rd_addr (scan_ptr_ff[LRU_AW-1:0]),
      .rd_data (lru_rdata)
   );

   // span length of a contiguous read, capped by the file slot count and LEN_MAX
   assign span_diff = req_last_sector - req_sector;
   always_comb begin
      if (req_last_sector <= req_sector) begin
         span_len = COUNT_W'(1);
      end else if (span_diff >= SECTOR_W'(LEN_CAP - 1)) begin
         span_len = COUNT_W'(LEN_CAP);
      end else begin
         span_len = span_diff[COUNT_W-1:0] + COUNT_W'(1);
      end
   end

   assign block_wide   = {3'b000, sec_ff} << bf_ff;
   assign drive_block  = block_wide[BLOCK_W-1:0];
   assign count_single = COUNT_W'(1) << bf_ff;
   assign count_contig = len_ff << bf_ff;

   assign cur_valid  = valid_ff[cmp_idx_ff];
   assign tag_match  = cur_valid && (tag_rdata == sec_ff);
   assign victim_idx = inval_found_ff ? inval_idx_ff : min_idx_ff;

   always_comb begin
      bf_in          = bf_ff;
      act_in         = act_ff;
      sec_in         = sec_ff;
      rd_ok_in       = rd_ok_ff;
      len_in         = len_ff;
      use_ctr_in     = use_ctr_ff;
      valid_in       = valid_ff;
      scan_on_in     = scan_on_ff;
      scan_ptr_in    = scan_ptr_ff;
      scan_last_in   = scan_last_ff;
      cmp_vld_in     = 1'b0;
      cmp_idx_in     = scan_ptr_ff;
      found_in       = found_ff;
      hit_idx_in     = hit_idx_ff;
      inval_found_in = inval_found_ff;
      inval_idx_in   = inval_idx_ff;
      min_have_in    = min_have_ff;
      min_idx_in     = min_idx_ff;
      min_val_in     = min_val_ff;
      fill_ptr_in    = fill_ptr_ff;
      fill_sec_in    = fill_sec_ff;
      fill_rem_in    = fill_rem_ff;
      res_in         = res_ff;
      out_vld_in     = out_vld_ff;
      out_in         = out_ff;
      tag_we         = 1'b0;
      tag_waddr      = victim_idx;
      tag_wdata      = sec_ff;
      lru_we         = 1'b0;
      lru_waddr      = victim_idx[LRU_AW-1:0];

      if (csr_wr_en) begin
         bf_in = csr_wr_data;
      end

      // one slot read issued per cycle, compared in the cycle after
      if (scan_on_ff) begin
         cmp_vld_in = 1'b1;
         if (scan_ptr_ff == scan_last_ff) begin
            scan_on_in = 1'b0;
         end else begin
            scan_ptr_in = scan_ptr_ff + IDX_W'(1);
         end
      end

      if (cmp_vld_ff) begin
         if (tag_match && !found_ff) begin
            found_in   = 1'b1;
            hit_idx_in = cmp_idx_ff;
         end
         if (!cur_valid && !inval_found_ff) begin
            inval_found_in = 1'b1;
            inval_idx_in   = cmp_idx_ff;
         end
         if (cur_valid && (!min_have_ff || (lru_rdata < min_val_ff))) begin
            min_have_in = 1'b1;
            min_idx_in  = cmp_idx_ff;
            min_val_in  = lru_rdata;
         end
      end

      if (cmd.capture) begin
         act_in         = req_action;
         sec_in         = req_sector;
         rd_ok_in       = req_read_ok;
         len_in         = span_len;
         found_in       = 1'b0;
         inval_found_in = 1'b0;
         min_have_in    = 1'b0;
         res_in         = '0;
         res_in.ok      = 1'b1;
         if (req_action == ACT_SINGLE) begin
            use_ctr_in   = use_ctr_ff + STAMP_W'(1);
            scan_on_in   = 1'b1;
            scan_ptr_in  = '0;
            scan_last_in = IDX_W'(STD_SLOTS - 1);
         end else if (req_action == ACT_CONTIG) begin
            scan_on_in   = 1'b1;
            scan_ptr_in  = IDX_W'(STD_SLOTS);
            scan_last_in = IDX_W'(TOTAL - 1);
         end else if (req_action == ACT_INVAL) begin
            valid_in = '0;
         end
      end

      if (cmd.decide) begin
         res_in = '0;
         if (found_ff) begin
            res_in.hit  = 1'b1;
            res_in.slot = SLOT_W'(hit_idx_ff);
            res_in.ok   = 1'b1;
            if (act_ff == ACT_SINGLE) begin
               lru_we    = 1'b1;
               lru_waddr = hit_idx_ff[LRU_AW-1:0];
            end
         end else begin
            res_in.read_issued = 1'b1;
            res_in.drive_block = drive_block;
            res_in.drive_count = (act_ff == ACT_SINGLE) ? count_single : count_contig;
            res_in.ok          = rd_ok_ff;
            if (!rd_ok_ff) begin
               valid_in = '0;
            end else if (act_ff == ACT_SINGLE) begin
               res_in.slot          = SLOT_W'(victim_idx);
               tag_we               = 1'b1;
               lru_we               = 1'b1;
               valid_in[victim_idx] = 1'b1;
            end else begin
               res_in.slot = SLOT_W'(STD_SLOTS);
               fill_ptr_in = IDX_W'(STD_SLOTS);
               fill_sec_in = sec_ff;
               fill_rem_in = len_ff;
            end
         end
      end

      if (cmd.fill) begin
         tag_we                = 1'b1;
         tag_waddr             = fill_ptr_ff;
         tag_wdata             = fill_sec_ff;
         valid_in[fill_ptr_ff] = 1'b1;
         fill_ptr_in           = fill_ptr_ff + IDX_W'(1);
         fill_sec_in           = fill_sec_ff + SECTOR_W'(1);
         fill_rem_in           = fill_rem_ff - COUNT_W'(1);
      end

      if (cmd.load_out) begin
         out_vld_in = 1'b1;
         out_in     = res_ff;
      end else if (rsp_ready) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bf_ff      <= '0;
         use_ctr_ff <= '0;
         valid_ff   <= '0;
         scan_on_ff <= 1'b0;
         cmp_vld_ff <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         bf_ff      <= bf_in;
         use_ctr_ff <= use_ctr_in;
         valid_ff   <= valid_in;
         scan_on_ff <= scan_on_in;
         cmp_vld_ff <= cmp_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff         <= act_in;
      sec_ff         <= sec_in;
      rd_ok_ff       <= rd_ok_in;
      len_ff         <= len_in;
      scan_ptr_ff    <= scan_ptr_in;
      scan_last_ff   <= scan_last_in;
      cmp_idx_ff     <= cmp_idx_in;
      found_ff       <= found_in;
      hit_idx_ff     <= hit_idx_in;
      inval_found_ff <= inval_found_in;
      inval_idx_ff   <= inval_idx_in;
      min_have_ff    <= min_have_in;
      min_idx_ff     <= min_idx_in;
      min_val_ff     <= min_val_in;
      fill_ptr_ff    <= fill_ptr_in;
      fill_sec_ff    <= fill_sec_in;
      fill_rem_ff    <= fill_rem_in;
      res_ff         <= res_in;
      out_ff         <= out_in;
   end

   assign sts.req_lookup = (req_action == ACT_SINGLE) || (req_action == ACT_CONTIG);
   assign sts.scan_done  = cmp_vld_ff && (cmp_idx_ff == scan_last_ff);
   assign sts.need_fill  = (act_ff == ACT_CONTIG) && !found_ff && rd_ok_ff;
   assign sts.fill_last  = (fill_rem_ff == COUNT_W'(1));
   assign sts.out_free   = !out_vld_ff || rsp_ready;

   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_ff;

`ifndef SYNTHESIS
   // a failed drive read leaves no slot valid
   assert property (@(posedge clock) disable iff (reset)
      (cmd.decide && !found_ff && !rd_ok_ff) |=> (valid_ff == '0))
      else $error("slots still valid after failed drive read");

   assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && out_ff.hit) |-> (!out_ff.read_issued && out_ff.ok))
      else $error("hit beat reports a drive read");

   // fills never start below the first file slot and never run past the span
   assert property (@(posedge clock) disable iff (reset)
      cmd.fill |-> ((fill_ptr_ff >= IDX_W'(STD_SLOTS)) && (fill_rem_ff != '0)))
      else $error("fill outside file slots");

   assert property (@(posedge clock) disable iff (reset)
      scan_on_ff |-> (scan_ptr_ff <= scan_last_ff))
      else $error("scan pointer past end of range");
`endif

endmodule

[sim/testbench.sv]
`timescale 1ns / 100ps

module testbench;
   import sbc_pkg::*;

   localparam int NUM_STD      = 8;
   localparam int NUM_FILE     = 8;
   localparam int NUM_SLOTS    = NUM_STD + NUM_FILE;
   localparam int NUM_PHASES   = 6;
   localparam int PHASE_ITEMS  = 225;
   localparam int STALL_LIMIT  = 2000;
   localparam int HOLD_CYCLES  = 200;
   localparam int SETTLE_CYCLES = 30;
   localparam int MAX_REPORTS  = 10;
   localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
   // blocking factor per random phase, phase 0 in the low bits
   localparam logic [BF_W*NUM_PHASES-1:0] BF_PLAN = {2'd0, 2'd3, 2'd1, 2'd2, 2'd0, 2'd3};

   typedef struct {
      logic [ACTION_W-1:0] action;
      logic [SECTOR_W-1:0] sector;
      logic [SECTOR_W-1:0] last_sector;
      logic                read_ok;
      logic                typed;
      result_type          want;
   } access_row_type;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [BF_W-1:0] csr_wr_data;

   sbc_req_if req_ch ();
   sbc_rsp_if rsp_ch ();

   sector_buffer_cache_lru #(
      .STD_SLOTS  (NUM_STD),
      .FILE_SLOTS (NUM_FILE)
   ) i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // tag store mirror
   logic [SECTOR_W-1:0] tag_sector [NUM_SLOTS];
   logic                tag_valid  [NUM_SLOTS];
   logic [STAMP_W-1:0]  use_stamp  [NUM_STD];
   logic [STAMP_W-1:0]  use_count;
   logic [BF_W-1:0]     blk_shift;

   result_type     pending_results [$];
   access_row_type directed_rows [$];
   int             n_fail = 0;
   int             quiet_cycles = 0;
   logic           no_idle = 1'b0;
   logic           hold_request = 1'b0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void clear_tags();
      for (int k = 0; k < NUM_SLOTS; k++)
         tag_valid[k] = 1'b0;
   endfunction

   function automatic result_type cache_access(input access_row_type a);
      result_type          r;
      int                  k;
      int                  victim;
      int                  span;
      logic [SECTOR_W+3:0] blk_wide;
      logic [15:0]         cnt_wide;
      r = '0;
      r.ok = 1'b1;
      blk_wide = {4'd0, a.sector} << blk_shift;
      case (a.action)
         ACT_SINGLE: begin
            use_count = use_count + STAMP_W'(1);
            for (k = 0; k < NUM_STD; k++)
               if (tag_valid[k] && tag_sector[k] == a.sector) begin
                  use_stamp[k] = use_count;
                  r.hit = 1'b1;
                  r.slot = SLOT_W'(k);
                  return r;
               end
            victim = -1;
            for (k = 0; k < NUM_STD; k++)
               if (!tag_valid[k] && victim < 0)
                  victim = k;
            // all valid: oldest stamp, lowest index on a tie
            if (victim < 0) begin
               victim = 0;
               for (k = 1; k < NUM_STD; k++)
                  if (use_stamp[k] < use_stamp[victim])
                     victim = k;
            end
            cnt_wide = 16'd1 << blk_shift;
            r.read_issued = 1'b1;
            r.drive_block = blk_wide[BLOCK_W-1:0];
            r.drive_count = cnt_wide[COUNT_W-1:0];
            if (a.read_ok) begin
               tag_sector[victim] = a.sector;
               tag_valid[victim] = 1'b1;
               use_stamp[victim] = use_count;
               r.slot = SLOT_W'(victim);
            end else begin
               clear_tags();
               r.ok = 1'b0;
            end
         end
         ACT_CONTIG: begin
            for (k = NUM_STD; k < NUM_SLOTS; k++)
               if (tag_valid[k] && tag_sector[k] == a.sector) begin
                  r.hit = 1'b1;
                  r.slot = SLOT_W'(k);
                  return r;
               end
            if (a.last_sector <= a.sector) begin
               span = 1;
            end else begin
               span = int'(a.last_sector - a.sector) + 1;
               if (span > NUM_FILE)
                  span = NUM_FILE;
               if (span > LEN_MAX)
                  span = LEN_MAX;
            end
            cnt_wide = 16'(span) << blk_shift;
            r.read_issued = 1'b1;
            r.drive_block = blk_wide[BLOCK_W-1:0];
            r.drive_count = cnt_wide[COUNT_W-1:0];
            if (a.read_ok) begin
               for (k = 0; k < span; k++) begin
                  tag_sector[NUM_STD+k] = a.sector + SECTOR_W'(k);
                  tag_valid[NUM_STD+k] = 1'b1;
               end
               r.slot = SLOT_W'(NUM_STD);
            end else begin
               clear_tags();
               r.ok = 1'b0;
            end
         end
         ACT_INVAL: begin
            clear_tags();
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   function automatic void add_row(input logic [ACTION_W-1:0] act, input int sec, input int last,
                                   input int rd_ok);
      access_row_type a;
      a.action = act;
      a.sector = SECTOR_W'(sec);
      a.last_sector = SECTOR_W'(last);
      a.read_ok = rd_ok[0];
      a.typed = 1'b0;
      a.want = '0;
      directed_rows.push_back(a);
   endfunction

   function automatic void add_checked(input logic [ACTION_W-1:0] act, input int sec,
                                       input int last, input int rd_ok, input int hit,
                                       input int slot, input int issued, input int blk,
                                       input int cnt, input int ok);
      access_row_type a;
      a.action = act;
      a.sector = SECTOR_W'(sec);
      a.last_sector = SECTOR_W'(last);
      a.read_ok = rd_ok[0];
      a.typed = 1'b1;
      a.want.hit = hit[0];
      a.want.slot = SLOT_W'(slot);
      a.want.read_issued = issued[0];
      a.want.drive_block = BLOCK_W'(blk);
      a.want.drive_count = COUNT_W'(cnt);
      a.want.ok = ok[0];
      directed_rows.push_back(a);
   endfunction

   function automatic access_row_type random_access(input logic [SECTOR_W-1:0] base);
      access_row_type a;
      int             pick;
      a.typed = 1'b0;
      a.want = '0;
      pick = $urandom_range(0, 99);
      if (pick < 56)
         a.action = ACT_SINGLE;
      else if (pick < 96)
         a.action = ACT_CONTIG;
      else if (pick < 98)
         a.action = ACT_INVAL;
      else
         a.action = ACT_UNUSED;
      // mostly a small working set so that hits and replacement happen
      if ($urandom_range(0, 19) == 0)
         a.sector = SECTOR_W'($urandom);
      else
         a.sector = base + SECTOR_W'($urandom_range(0, 11));
      pick = $urandom_range(0, 9);
      if (pick < 7)
         a.last_sector = a.sector + SECTOR_W'($urandom_range(0, 10));
      else if (pick < 9)
         a.last_sector = SECTOR_W'($urandom);
      else
         a.last_sector = a.sector - SECTOR_W'($urandom_range(1, 4));
      a.read_ok = ($urandom_range(0, 39) != 0);
      return a;
   endfunction

   function automatic string fmt_result(input result_type r);
      return $sformatf("hit=%0d slot=%0d issued=%0d block=%h count=%0d ok=%0d",
                       r.hit, r.slot, r.read_issued, r.drive_block, r.drive_count, r.ok);
   endfunction

   function automatic void log_failure(input string msg);
      n_fail++;
      if (n_fail <= MAX_REPORTS)
         $display("%0t: %s", $time, msg);
   endfunction

   task automatic send_access(input access_row_type a);
      int         gap;
      result_type r;
      gap = no_idle ? 0 : $urandom_range(0, 5);
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.action <= a.action;
      req_ch.sector <= a.sector;
      req_ch.last_sector <= a.last_sector;
      req_ch.read_ok <= a.read_ok;
      do @(posedge clock); while (!req_ch.ready);
      r = cache_access(a);
      pending_results.push_back(a.typed ? a.want : r);
   endtask

   task automatic check_result(input result_type got);
      result_type want;
      if (pending_results.size() == 0) begin
         log_failure({"result beat with nothing pending: ", fmt_result(got)});
         return;
      end
      want = pending_results.pop_front();
      if (got.hit !== want.hit || got.slot !== want.slot ||
          got.read_issued !== want.read_issued || got.drive_block !== want.drive_block ||
          got.drive_count !== want.drive_count || got.ok !== want.ok)
         log_failure({"result mismatch: exp ", fmt_result(want), " got ", fmt_result(got)});
   endtask

   // result side
   initial begin
      int         gap;
      result_type got;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         gap = no_idle ? 0 : $urandom_range(0, 5);
         if (hold_request) begin
            hold_request = 1'b0;
            gap = HOLD_CYCLES;
         end
         if (gap != 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         got.hit = rsp_ch.hit;
         got.slot = rsp_ch.slot;
         got.read_issued = rsp_ch.read_issued;
         got.drive_block = rsp_ch.drive_block;
         got.drive_count = rsp_ch.drive_count;
         got.ok = rsp_ch.ok;
         check_result(got);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == STALL_LIMIT) begin
         $display("%0t: no beat accepted for %0d cycles", $time, STALL_LIMIT);
         $display("end of test: mismatches");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // request side and register writes
   initial begin
      logic [SECTOR_W-1:0] base;
      logic [BF_W-1:0]     bf_next;
      reset <= 1'b1;
      csr_wr_en <= 1'b0;
      csr_wr_data <= '0;
      req_ch.valid <= 1'b0;
      req_ch.action <= ACT_SINGLE;
      req_ch.sector <= '0;
      req_ch.last_sector <= '0;
      req_ch.read_ok <= 1'b0;
      for (int k = 0; k < NUM_SLOTS; k++) begin
         tag_sector[k] = '0;
         tag_valid[k] = 1'b0;
      end
      for (int k = 0; k < NUM_STD; k++)
         use_stamp[k] = '0;
      use_count = '0;
      blk_shift = '0;

      // blocking factor 0 from reset
      add_checked(ACT_SINGLE, 0, 0, 1, 0, 0, 1, 0, 1, 1);
      add_checked(ACT_SINGLE, 'hFFFFFF, 0, 1, 0, 1, 1, 'h1FFFFF, 1, 1);
      // hit ignores read_ok
      add_checked(ACT_SINGLE, 0, 'hFFFFFF, 0, 1, 0, 0, 0, 0, 1);
      add_checked(ACT_SINGLE, 'hFFFFFF, 0, 1, 1, 1, 0, 0, 0, 1);
      for (int s = 1; s <= 6; s++)
         add_row(ACT_SINGLE, s, 0, 1);
      // set full: least recently used slot goes
      add_row(ACT_SINGLE, 7, 0, 1);
      add_row(ACT_SINGLE, 0, 0, 1);
      // failed drive read drops every slot
      add_checked(ACT_SINGLE, 'h123456, 0, 0, 0, 0, 1, 'h123456, 1, 0);
      add_checked(ACT_CONTIG, 100, 103, 1, 0, 8, 1, 100, 4, 1);
      add_checked(ACT_CONTIG, 102, 0, 0, 1, 10, 0, 0, 0, 1);
      add_checked(ACT_CONTIG, 0, 'hFFFFFF, 1, 0, 8, 1, 0, 8, 1);
      add_checked(ACT_CONTIG, 7, 0, 1, 1, 15, 0, 0, 0, 1);
      add_checked(ACT_CONTIG, 200, 200, 1, 0, 8, 1, 200, 1, 1);
      // stale file slot from the longer run still hits
      add_checked(ACT_CONTIG, 5, 5, 1, 1, 13, 0, 0, 0, 1);
      add_checked(ACT_CONTIG, 'hFFFFFC, 'hFFFFFF, 1, 0, 8, 1, 'h1FFFFC, 4, 1);
      add_checked(ACT_CONTIG, 300, 310, 0, 0, 0, 1, 300, 8, 0);
      add_checked(ACT_CONTIG, 5, 4, 1, 0, 8, 1, 5, 1, 1);
      add_checked(ACT_INVAL, 'hFFFFFF, 'hFFFFFF, 0, 0, 0, 0, 0, 0, 1);
      add_checked(ACT_UNUSED, 'hABCDEF, 'h123456, 1, 0, 0, 0, 0, 0, 1);
      add_checked(ACT_SINGLE, 9, 0, 1, 0, 0, 1, 9, 1, 1);

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         send_access(directed_rows[i]);

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         req_ch.valid <= 1'b0;
         while (pending_results.size() != 0) @(posedge clock);
         repeat (SETTLE_CYCLES) @(posedge clock);
         bf_next = BF_PLAN[BF_W*phase +: BF_W];
         csr_wr_en <= 1'b1;
         csr_wr_data <= bf_next;
         @(posedge clock);
         csr_wr_en <= 1'b0;
         blk_shift = bf_next;
         no_idle = (phase == 1);
         base = SECTOR_W'($urandom);
         if (phase == NUM_PHASES - 1)
            base = 24'hFFFFF8;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // long receiver stall while requests keep coming
            if (phase == 2 && n == 20)
               hold_request = 1'b1;
            if (n % 75 == 74)
               base = SECTOR_W'($urandom);
            send_access(random_access(base));
         end
      end

      req_ch.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (n_fail == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

[files.f]
sv/sbc_pkg.sv
sv/sbc_ifs.sv
sv/sbc_ram.sv
sv/sbc_ctrl.sv
sv/sbc_datapath.sv
sv/sector_buffer_cache_lru.sv
sim/testbench.sv
